// ----- rtl/combined_lcg_shuffle_rng_macros.svh -----
// Assertion macros for the combined LCG shuffle generator
`ifndef COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH
`ifndef NO_ASSERTIONS
// check a property outside reset
`define CLSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// check a property at every edge, reset included
`define CLSR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: reset check failed");
`else
`define CLSR_ASSERT(lbl, prop)
`define CLSR_ASSERT_RST(lbl, prop)
`endif
`endif

// ----- rtl/clsr_pkg.sv -----
// Shared constants and controller/datapath interface types
package clsr_pkg;

  localparam int XW = 31;
  localparam int TABLE_SIZE_DEF = 32;
  localparam int WARMUP = 8;

  localparam logic [XW-1:0] MOD1 = 31'd2147483563;
  localparam logic [XW-1:0] MOD2 = 31'd2147483399;
  localparam logic [15:0] MUL1 = 16'd40014;
  localparam logic [15:0] MUL2 = 16'd40692;
  localparam logic [7:0] FOLD1 = 8'd85;
  localparam logic [7:0] FOLD2 = 8'd249;
  localparam logic [XW-1:0] SECOND_INIT = 31'd123456789;

  typedef struct packed {
    logic load_seed;
    logic step_go;
    logic seed_cap;
    logic draw_cap;
    logic finish;
  } clsr_cmd_t;

  typedef struct packed {
    logic step_done;
    logic cnt_zero;
    logic out_busy;
  } clsr_sts_t;

endpackage

// ----- rtl/clsr_step.sv -----
// Two-lane modular multiply step unit
module clsr_step import clsr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [XW-1:0] x1,
  input  logic [XW-1:0] x2,
  output logic          done,
  output logic [XW-1:0] r1,
  output logic [XW-1:0] r2
);

  localparam int PW = XW + 16;

  logic [PW-1:0] p1_r, p2_r;
  logic [XW:0]   s1_r, s2_r;
  logic          v1_r, v2_r;

  always_ff @(posedge clk) begin
    p1_r <= PW'(x1) * PW'(MUL1);
    p2_r <= PW'(x2) * PW'(MUL2);
    s1_r <= (XW+1)'(p1_r[PW-1:XW]) * (XW+1)'(FOLD1) + (XW+1)'(p1_r[XW-1:0]);
    s2_r <= (XW+1)'(p2_r[PW-1:XW]) * (XW+1)'(FOLD2) + (XW+1)'(p2_r[XW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
    end
  end

  assign r1 = (s1_r >= (XW+1)'(MOD1)) ? XW'(s1_r - (XW+1)'(MOD1)) : s1_r[XW-1:0];
  assign r2 = (s2_r >= (XW+1)'(MOD2)) ? XW'(s2_r - (XW+1)'(MOD2)) : s2_r[XW-1:0];
  assign done = v2_r;

endmodule

// ----- rtl/clsr_dpath.sv -----
// Datapath: generators, shuffle table, index, result register
module clsr_dpath import clsr_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  clsr_cmd_t     cmd,
  output clsr_sts_t     sts,
  input  logic          cfg_wr_en,
  input  logic [XW-1:0] cfg_wr_data,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [XW-1:0] out_sample
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + WARMUP);
  localparam logic [63:0] BUCKET = 64'(1 + (64'(MOD1) - 64'd1) / 64'(TABLE_SIZE));

  logic [XW-1:0] seed_r, x1_r, x2_r, last_r, rd_r, out_sample_r;
  logic [IW-1:0] idx_r, idx_c, wr_addr_c;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r, wr_en_c, step_done;
  logic [XW-1:0] seed0_c, r1, r2, wr_data_c, y_c;
  logic [XW+1:0] diff_c;
  logic [XW-1:0] tbl_mem [TABLE_SIZE];

  clsr_step u_step (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.step_go),
    .x1   (x1_r),
    .x2   (x2_r),
    .done (step_done),
    .r1   (r1),
    .r2   (r2)
  );

  assign seed0_c = (seed_r == '0) ? XW'(1) : seed_r;

  always_comb begin
    idx_c = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if ({33'd0, last_r} >= 64'(k) * BUCKET) idx_c = IW'(k);
    end
  end

  always_comb begin
    diff_c = {2'b00, rd_r} - {2'b00, x2_r};
    if (diff_c[XW+1] || diff_c == '0) begin
      y_c = XW'(diff_c + (XW+2)'(MOD1 - XW'(1)));
    end else begin
      y_c = diff_c[XW-1:0];
    end
  end

  always_comb begin
    wr_en_c   = 1'b0;
    wr_addr_c = idx_r;
    wr_data_c = x1_r;
    if (cmd.finish) begin
      wr_en_c = 1'b1;
    end else if (cmd.seed_cap && cnt_r < CW'(TABLE_SIZE)) begin
      wr_en_c   = 1'b1;
      wr_addr_c = cnt_r[IW-1:0];
      wr_data_c = r1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en_c) tbl_mem[wr_addr_c] <= wr_data_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.step_go) begin
      rd_r  <= tbl_mem[idx_c];
      idx_r <= idx_c;
    end
    if (cmd.finish) out_sample_r <= y_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= XW'(1);
      x1_r        <= '0;
      x2_r        <= SECOND_INIT;
      last_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) seed_r <= cfg_wr_data;
      if (cmd.load_seed) begin
        x1_r  <= seed0_c;
        x2_r  <= seed0_c;
        cnt_r <= CW'(TABLE_SIZE + WARMUP - 1);
      end
      if (cmd.seed_cap) begin
        x1_r <= r1;
        if (cnt_r == '0) begin
          last_r <= r1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
      if (cmd.draw_cap) begin
        x1_r <= r1;
        x2_r <= r2;
      end
      if (cmd.finish) begin
        last_r      <= y_c;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.step_done = step_done;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.out_busy  = out_valid_r & out_stall;
  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;

endmodule

// ----- rtl/clsr_ctrl.sv -----
// Controller: sequences seeding, table fill and draws
`include "combined_lcg_shuffle_rng_macros.svh"
module clsr_ctrl import clsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_reseed,
  output logic      in_stall,
  input  clsr_sts_t sts,
  output clsr_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SEED_GO   = 6'b000010,
    ST_SEED_WAIT = 6'b000100,
    ST_DRAW_GO   = 6'b001000,
    ST_DRAW_WAIT = 6'b010000,
    ST_DRAW_FIN  = 6'b100000
  } clsr_state_t;

  clsr_state_t state_r, state_nxt;
  logic        seeded_r, seeded_nxt;

  always_comb begin
    state_nxt  = state_r;
    seeded_nxt = seeded_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_reseed || !seeded_r) begin
            cmd.load_seed = 1'b1;
            state_nxt     = ST_SEED_GO;
          end else begin
            cmd.step_go = 1'b1;
            state_nxt   = ST_DRAW_WAIT;
          end
        end
      end
      ST_SEED_GO: begin
        cmd.step_go = 1'b1;
        state_nxt   = ST_SEED_WAIT;
      end
      ST_SEED_WAIT: begin
        if (sts.step_done) begin
          cmd.seed_cap = 1'b1;
          if (sts.cnt_zero) begin
            seeded_nxt = 1'b1;
            state_nxt  = ST_DRAW_GO;
          end else begin
            state_nxt = ST_SEED_GO;
          end
        end
      end
      ST_DRAW_GO: begin
        cmd.step_go = 1'b1;
        state_nxt   = ST_DRAW_WAIT;
      end
      ST_DRAW_WAIT: begin
        if (sts.step_done) begin
          cmd.draw_cap = 1'b1;
          state_nxt    = ST_DRAW_FIN;
        end
      end
      ST_DRAW_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      seeded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seeded_r <= seeded_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  `CLSR_ASSERT_RST(a_reset_idle, !rst_n |=> state_r == ST_IDLE)
  `CLSR_ASSERT(a_done_in_wait, sts.step_done |-> (state_r == ST_SEED_WAIT || state_r == ST_DRAW_WAIT))
  `CLSR_ASSERT(a_accept_blocks, (in_valid && !in_stall) |=> in_stall)
  `CLSR_ASSERT(a_seeded_holds, seeded_r |=> seeded_r)
  `CLSR_ASSERT(a_fin_after_wait, state_r == ST_DRAW_FIN |-> ($past(state_r) == ST_DRAW_WAIT || $past(state_r) == ST_DRAW_FIN))

endmodule

// ----- rtl/combined_lcg_shuffle_rng.sv -----
// A new draw is accepted only while the controller is idle; in_stall is high
// from accept until that draw's result has been written.
// Seeding (first beat after reset or reseed) first steps the generator TABLE_SIZE+8 times.
// A waiting result does not block the next accept; only the final write waits.
// Reset (rst_n low, synchronous): controller idle, unseeded, seed register 1.
// The shuffle table is not cleared; seeding writes every entry before use.
module combined_lcg_shuffle_rng import clsr_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [XW-1:0] cfg_wr_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_reseed,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [XW-1:0] out_sample
);

  clsr_cmd_t cmd;
  clsr_sts_t sts;

  clsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_reseed(in_reseed),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  clsr_dpath #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_sample (out_sample)
  );

endmodule
